// ===== rtl/sha256_hash_engine_assert.svh =====
// Assertion macros for the SHA-256 engine RTL (used by sha_ctrl).
// Expects clk and rst_n in the scope of each use.
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define SHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 assertion failed");

// Next-cycle implication.
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 assertion failed");

`endif

// ===== rtl/sha_pkg.sv =====
// Types, constants and round functions for the SHA-256 engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PAD80 = 8'b0000_0010,
        S_ZERO  = 8'b0000_0100,
        S_LEN   = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_ROUND = 8'b0010_0000,
        S_ADD   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        SEL_MSG  = 2'd0,
        SEL_PAD  = 2'd1,
        SEL_ZERO = 2'd2,
        SEL_LEN  = 2'd3
    } byte_sel_t;

    typedef struct packed {
        logic      wr_byte;
        byte_sel_t byte_sel;
        logic      load_work;
        logic      round;
        logic      add_hash;
        logic      restart;
        logic [5:0] round_idx;
        logic [2:0] word_idx;
    } cmd_t;

    typedef struct packed {
        logic [5:0] ptr;
    } status_t;

    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [5:0]  LAST_POS = 6'd63;

    function automatic logic [31:0] init_word(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] r;
        case (i)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sha_ctrl.sv =====
// Sequencer for the SHA-256 engine: byte intake, padding, rounds, digest output.
// Depends on sha_pkg and sha256_hash_engine_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_hash_engine_assert.svh"
module sha_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic            byte_valid,
    input  wire logic            is_last,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic                 last_word,
    input  wire sha_pkg::status_t status,
    output sha_pkg::cmd_t        cmd
);
    import sha_pkg::*;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [5:0] round_cnt_reg, round_cnt_next;
    logic [2:0] out_cnt_reg, out_cnt_next;
    logic       wrap;

    assign wrap      = (status.ptr == LAST_POS);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign last_word = (out_cnt_reg == 3'd7);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        round_cnt_next = round_cnt_reg;
        out_cnt_next   = out_cnt_reg;
        cmd            = '0;
        cmd.byte_sel   = SEL_MSG;
        cmd.round_idx  = round_cnt_reg;
        cmd.word_idx   = out_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_valid)
                    begin
                        cmd.wr_byte = 1'b1;
                        if (wrap)
                        begin
                            ret_next   = is_last ? S_PAD80 : S_IDLE;
                            state_next = S_LOAD;
                        end
                        else if (is_last)
                        begin
                            state_next = S_PAD80;
                        end
                    end
                    else if (is_last)
                    begin
                        state_next = S_PAD80;
                    end
                end
            end
            S_PAD80:
            begin
                cmd.wr_byte  = 1'b1;
                cmd.byte_sel = SEL_PAD;
                if (wrap)
                begin
                    ret_next   = S_ZERO;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_ZERO;
                end
            end
            S_ZERO:
            begin
                if (status.ptr == LEN_POS)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.wr_byte  = 1'b1;
                    cmd.byte_sel = SEL_ZERO;
                    if (wrap)
                    begin
                        ret_next   = S_ZERO;
                        state_next = S_LOAD;
                    end
                end
            end
            S_LEN:
            begin
                cmd.wr_byte  = 1'b1;
                cmd.byte_sel = SEL_LEN;
                if (wrap)
                begin
                    ret_next   = S_OUT;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_work  = 1'b1;
                round_cnt_next = '0;
                state_next     = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round      = 1'b1;
                round_cnt_next = round_cnt_reg + 6'd1;
                if (round_cnt_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_hash = 1'b1;
                out_cnt_next = '0;
                state_next   = ret_reg;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    out_cnt_next = out_cnt_reg + 3'd1;
                    if (out_cnt_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            round_cnt_reg <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            round_cnt_reg <= round_cnt_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    `SHA_ASSERT_NOW(a_no_intake_while_out, out_valid, in_stall)
    `SHA_ASSERT_NEXT(a_round_to_add, (state_reg == S_ROUND) && (round_cnt_reg == 6'd63), state_reg == S_ADD)
    `SHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_cnt_reg))
    `SHA_ASSERT_NEXT(a_load_then_round, state_reg == S_LOAD, (state_reg == S_ROUND) && (round_cnt_reg == 6'd0))

endmodule
`default_nettype wire

// ===== rtl/sha_datapath.sv =====
// Datapath for the SHA-256 engine: block buffer and schedule window, working
// variables, hash words and byte counter. Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sha_pkg::cmd_t   cmd,
    input  wire logic [7:0]      message_byte,
    output sha_pkg::status_t     status,
    output logic [31:0]          digest_word
);
    import sha_pkg::*;

    logic [31:0] hash_reg [8];
    logic [31:0] work_reg [8];
    logic [31:0] work_next [8];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [60:0] total_reg;
    logic [5:0]  ptr_reg;
    logic [63:0] bit_len;
    logic [7:0]  wr_val;
    logic [31:0] s0, s1, sched, wt, t1, t2, e, a;

    assign status.ptr  = ptr_reg;
    assign digest_word = hash_reg[cmd.word_idx];
    assign bit_len     = {total_reg, 3'b000};

    always_comb
    begin
        case (cmd.byte_sel)
            SEL_MSG:  wr_val = message_byte;
            SEL_PAD:  wr_val = PAD_BYTE;
            SEL_ZERO: wr_val = 8'h00;
            SEL_LEN:  wr_val = 8'(bit_len >> (6'd8 * (3'd7 - ptr_reg[2:0])));
            default:  wr_val = 8'h00;
        endcase
    end

    always_comb
    begin
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sched = s1 + w_reg[9] + s0 + w_reg[0];
        wt = (cmd.round_idx[5:4] == 2'b00) ? w_reg[0] : sched;
        e  = work_reg[4];
        a  = work_reg[0];
        t1 = work_reg[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & work_reg[5]) ^ (~e & work_reg[6])) + round_k(cmd.round_idx) + wt;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & work_reg[1]) ^ (a & work_reg[2]) ^ (work_reg[1] & work_reg[2]));
    end

    always_comb
    begin
        w_next    = w_reg;
        work_next = work_reg;
        if (cmd.wr_byte)
        begin
            w_next[ptr_reg[5:2]][8 * (3 - ptr_reg[1:0]) +: 8] = wr_val;
        end
        if (cmd.load_work)
        begin
            work_next = hash_reg;
        end
        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15]   = wt;
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + t2;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_word(3'(i));
            end
            total_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            if (cmd.wr_byte)
            begin
                ptr_reg <= ptr_reg + 6'd1;
            end
            if (cmd.wr_byte && (cmd.byte_sel == SEL_MSG))
            begin
                total_reg <= total_reg + 61'd1;
            end
            if (cmd.add_hash)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= init_word(3'(i));
                end
                total_reg <= '0;
                ptr_reg   <= '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sha256_hash_engine.sv =====
// Top level of the SHA-256 engine: joins the sequencer and the datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    message_byte, byte_valid, is_last
//   output    out_valid / out_stall  digest_word, last_word
//
// A byte request is taken while idle; the 64th byte of a block starts the
// compression (load, 64 rounds at one per cycle, hash add). A finishing
// request pads one byte per cycle (pausing on a full block) to position 56,
// writes 8 length bytes, runs one or two compressions, then offers 8 digest
// words. in_stall is high whenever the sequencer is not waiting for input.
// Reset restores the initial hash words and clears the byte count.
`timescale 1ns / 1ps
`default_nettype none
module sha256_hash_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  message_byte,
    input  wire logic        byte_valid,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic             last_word
);
    import sha_pkg::*;

    cmd_t    cmd;
    status_t status;

    sha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_valid (byte_valid),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .last_word  (last_word),
        .status     (status),
        .cmd        (cmd)
    );

    sha_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .message_byte (message_byte),
        .status       (status),
        .digest_word  (digest_word)
    );

endmodule
`default_nettype wire
